### rtl/acp_pkg.sv
// shared types, constants and decode functions of the ascii can command parser
package acp_pkg;

    localparam int LINE_DEPTH = 40;
    localparam int POS_W      = $clog2(LINE_DEPTH + 1);

    localparam int CHAR_W     = 8;
    localparam int RATE_W     = 20;
    localparam int ID_W       = 12;
    localparam int LEN_W      = 4;
    localparam int PAYLOAD_W  = 64;
    localparam int MAX_BYTES  = 8;

    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_OPEN   = 8'h4F;
    localparam logic [CHAR_W-1:0] CHAR_CLOSE  = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_SPEED  = 8'h53;
    localparam logic [CHAR_W-1:0] CHAR_TX     = 8'h74;

    localparam logic [POS_W-1:0] POS_CMD        = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ID_LAST    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LEN        = POS_W'(4);
    localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(5);
    localparam logic [POS_W-1:0] POS_DATA_LAST  = POS_W'(20);
    localparam logic [POS_W-1:0] POS_MAX        = POS_W'(LINE_DEPTH);

    typedef enum logic [1:0] {
        ACT_OPEN     = 2'd0,
        ACT_CLOSE    = 2'd1,
        ACT_SET_RATE = 2'd2,
        ACT_TRANSMIT = 2'd3
    } action_t;

    typedef struct packed {
        logic                   emit;
        action_t                action;
        logic [RATE_W-1:0]      bit_rate;
        logic [ID_W-1:0]        frame_id;
        logic [LEN_W-1:0]       frame_length;
        logic [PAYLOAD_W-1:0]   frame_payload;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [3:0] h;
        h = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            h = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    function automatic logic [RATE_W-1:0] rate_of(input logic [CHAR_W-1:0] c);
        logic [RATE_W-1:0] r;
        case (c)
            8'h30:   r = RATE_W'(10000);
            8'h31:   r = RATE_W'(20000);
            8'h32:   r = RATE_W'(50000);
            8'h33:   r = RATE_W'(100000);
            8'h34:   r = RATE_W'(125000);
            8'h35:   r = RATE_W'(250000);
            8'h36:   r = RATE_W'(500000);
            8'h37:   r = RATE_W'(800000);
            8'h38:   r = RATE_W'(1000000);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic rate_ok(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h38);
    endfunction

endpackage

### rtl/acp_in_if.sv
// character input channel
interface acp_in_if;
    logic                         valid;
    logic                         ready;
    logic [acp_pkg::CHAR_W-1:0]   rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

### rtl/acp_out_if.sv
// command result channel
interface acp_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     action;
    logic [acp_pkg::RATE_W-1:0]     bit_rate;
    logic [acp_pkg::ID_W-1:0]       frame_id;
    logic [acp_pkg::LEN_W-1:0]      frame_length;
    logic [acp_pkg::PAYLOAD_W-1:0]  frame_payload;

    modport source (output valid, output action, output bit_rate, output frame_id,
                    output frame_length, output frame_payload, input ready);
    modport sink   (input valid, input action, input bit_rate, input frame_id,
                    input frame_length, input frame_payload, output ready);
endinterface

### rtl/ascii_can_command_line_parser_core.sv
// top level of the ascii can command parser: input register, decoder, result register
// Accepts one character item per clock unless a result stalls, and returns a result
// via the input and result registers after the carriage return ending its line; lines
// that end without a valid command yield no item. Throughput is one character per
// cycle unless a result stalls, set by the single decode stage between the input and
// result registers; a stalled result holds the next character in the input register.
// Commands: O opens and C closes the bus, S with a digit 0 to 8 selects the bit rate,
// t with three id digits, a length digit and data pairs transmits while open.
module ascii_can_command_line_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    acp_in_if.sink      in_ch,
    acp_out_if.source   out_ch
);

    logic                           in_valid_reg;
    logic [acp_pkg::CHAR_W-1:0]     char_reg;
    logic                           out_valid_reg, out_valid_next;
    acp_pkg::result_t               out_reg;
    acp_pkg::result_t               result;
    logic                           out_free;
    logic                           consume;
    logic                           in_take;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign consume  = in_valid_reg && out_free;
    assign in_take  = in_ch.valid && in_ch.ready;

    assign in_ch.ready = !in_valid_reg || consume;

    acp_line_decoder u_decoder
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (consume),
        .rx_char (char_reg),
        .result  (result)
    );

    always_comb
    begin
        if (consume)
        begin
            out_valid_next = result.emit;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= in_ch.rx_char;
        end
        if (consume && result.emit)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.action        = out_reg.action;
    assign out_ch.bit_rate      = out_reg.bit_rate;
    assign out_ch.frame_id      = out_reg.frame_id;
    assign out_ch.frame_length  = out_reg.frame_length;
    assign out_ch.frame_payload = out_reg.frame_payload;

    a_rate_only_for_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.action != acp_pkg::ACT_SET_RATE |-> out_reg.bit_rate == '0)
        else $error("bit rate set on a non rate result");

    a_length_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.action == acp_pkg::ACT_TRANSMIT
            |-> out_reg.frame_length <= acp_pkg::LEN_W'(acp_pkg::MAX_BYTES))
        else $error("transmit length above eight");

    a_held_char: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !consume |=> in_valid_reg && $stable(char_reg))
        else $error("pending character lost");

    a_silent_item_drains: assert property (@(posedge clk) disable iff (!rst_n)
        consume && !result.emit && out_ch.ready |=> !out_valid_reg)
        else $error("result repeated");

endmodule

### rtl/acp_line_decoder.sv
// line state, field decode and command execution for one character per step
module acp_line_decoder
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [acp_pkg::CHAR_W-1:0]   rx_char,
    output acp_pkg::result_t             result
);

    logic [acp_pkg::POS_W-1:0]      pos_reg,       pos_next;
    logic [acp_pkg::CHAR_W-1:0]     cmd_reg,       cmd_next;
    logic [acp_pkg::ID_W-1:0]       id_reg,        id_next;
    logic [acp_pkg::LEN_W-1:0]      len_reg,       len_next;
    logic [acp_pkg::PAYLOAD_W-1:0]  pay_reg,       pay_next;
    logic                           open_reg,      open_next;
    logic [acp_pkg::CHAR_W-1:0]     rate_char_reg, rate_char_next;

    logic [3:0]                     hex;
    logic [acp_pkg::POS_W-1:0]      pos_adv;
    logic [acp_pkg::POS_W-1:0]      arg_count;
    logic [acp_pkg::POS_W-1:0]      data_off;
    logic [3:0]                     nib_idx;
    logic [acp_pkg::POS_W-1:0]      pairs_raw;
    logic [acp_pkg::LEN_W-1:0]      pairs;
    logic                           is_cr;

    always_comb
    begin
        hex            = acp_pkg::hex_value(rx_char);
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        pay_next       = pay_reg;
        rate_char_next = rate_char_reg;
        open_next      = open_reg;
        pos_adv        = pos_reg;
        data_off       = pos_reg - acp_pkg::POS_DATA_FIRST;
        nib_idx        = {data_off[3:1], ~data_off[0]};
        is_cr          = (rx_char == acp_pkg::CHAR_CR);

        if (pos_reg < acp_pkg::POS_MAX)
        begin
            if (pos_reg == acp_pkg::POS_CMD)
            begin
                cmd_next       = rx_char;
                id_next        = '0;
                len_next       = '0;
                pay_next       = '0;
                rate_char_next = '0;
            end
            else if (pos_reg <= acp_pkg::POS_ID_LAST)
            begin
                case (pos_reg[1:0])
                    2'd1:
                    begin
                        id_next[11:8]  = id_reg[11:8] | hex;
                        rate_char_next = rx_char;
                    end
                    2'd2:    id_next[7:4] = id_reg[7:4] | hex;
                    2'd3:    id_next[3:0] = id_reg[3:0] | hex;
                    default: id_next      = id_reg;
                endcase
            end
            else if (pos_reg == acp_pkg::POS_LEN)
            begin
                len_next = hex;
            end
            else if (pos_reg <= acp_pkg::POS_DATA_LAST)
            begin
                for (int j = 0; j < acp_pkg::PAYLOAD_W / 4; j++)
                begin
                    if (nib_idx == 4'(j))
                    begin
                        pay_next[4*j +: 4] = pay_reg[4*j +: 4] | hex;
                    end
                end
            end
            pos_adv = pos_reg + acp_pkg::POS_W'(1);
        end

        arg_count = (pos_adv >= acp_pkg::POS_W'(2)) ? pos_adv - acp_pkg::POS_W'(2) : '0;
        pairs_raw = (arg_count - acp_pkg::POS_W'(4)) >> 1;
        pairs     = (pairs_raw > acp_pkg::POS_W'(len_next)) ? len_next
                                                            : acp_pkg::LEN_W'(pairs_raw);

        result = '0;
        if (step && is_cr)
        begin
            case (cmd_next)
                acp_pkg::CHAR_OPEN:
                begin
                    if (!open_reg)
                    begin
                        open_next     = 1'b1;
                        result.emit   = 1'b1;
                        result.action = acp_pkg::ACT_OPEN;
                    end
                end
                acp_pkg::CHAR_CLOSE:
                begin
                    if (open_reg)
                    begin
                        open_next     = 1'b0;
                        result.emit   = 1'b1;
                        result.action = acp_pkg::ACT_CLOSE;
                    end
                end
                acp_pkg::CHAR_SPEED:
                begin
                    if (arg_count != '0 && acp_pkg::rate_ok(rate_char_next))
                    begin
                        result.emit     = 1'b1;
                        result.action   = acp_pkg::ACT_SET_RATE;
                        result.bit_rate = acp_pkg::rate_of(rate_char_next);
                    end
                end
                acp_pkg::CHAR_TX:
                begin
                    if (open_reg && arg_count >= acp_pkg::POS_W'(4)
                        && len_next <= acp_pkg::LEN_W'(acp_pkg::MAX_BYTES))
                    begin
                        result.emit         = 1'b1;
                        result.action       = acp_pkg::ACT_TRANSMIT;
                        result.frame_id     = id_next;
                        result.frame_length = len_next;
                        for (int i = 0; i < acp_pkg::MAX_BYTES; i++)
                        begin
                            if (acp_pkg::LEN_W'(i) < pairs)
                            begin
                                result.frame_payload[8*i +: 8] = pay_next[8*i +: 8];
                            end
                        end
                    end
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end

        pos_next = is_cr ? '0 : pos_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cmd_reg       <= '0;
            id_reg        <= '0;
            len_reg       <= '0;
            pay_reg       <= '0;
            open_reg      <= 1'b0;
            rate_char_reg <= '0;
        end
        else if (step)
        begin
            pos_reg       <= pos_next;
            cmd_reg       <= cmd_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            pay_reg       <= pay_next;
            open_reg      <= open_next;
            rate_char_reg <= rate_char_next;
        end
    end

    a_pos_capped: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= acp_pkg::POS_MAX)
        else $error("line position beyond buffer depth");

    a_emit_on_cr: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit |-> step && rx_char == acp_pkg::CHAR_CR)
        else $error("result without carriage return");

    a_cr_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        step && rx_char == acp_pkg::CHAR_CR |=> pos_reg == '0)
        else $error("line not cleared after carriage return");

    a_open_toggles_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && !result.emit |=> $stable(open_reg))
        else $error("bus state changed without result");

endmodule

### tb/acp_parse_checker.sv
// checker for the ascii can command parser: follows the character items, predicts command results
`timescale 1ns / 1ps

module acp_parse_checker
    import acp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    acp_in_if    in_ch,
    acp_out_if   out_ch,
    output int   fail_count,
    output int   waiting,
    output int   compared
);

    typedef struct packed {
        action_t                action;
        logic [RATE_W-1:0]      rate;
        logic [ID_W-1:0]        id;
        logic [LEN_W-1:0]       len;
        logic [PAYLOAD_W-1:0]   data;
    } cmd_result_t;

    localparam int ID_DIGITS = 3;

    cmd_result_t            pending_cmds[$];
    int                     line_pos;
    logic [CHAR_W-1:0]      cmd_char;
    logic [CHAR_W-1:0]      speed_char;
    logic [ID_W-1:0]        id_acc;
    logic [LEN_W-1:0]       len_acc;
    logic [PAYLOAD_W-1:0]   data_acc;
    logic                   bus_up;
    int                     errs;
    int                     n_checked;

    function automatic logic [3:0] nibble_of(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 10);
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 10);
        return 4'd0;
    endfunction

    function automatic logic [RATE_W-1:0] speed_for(input logic [CHAR_W-1:0] c,
                                                    output logic ok);
        int idx;
        ok = (c >= "0" && c <= "8");
        idx = ok ? int'(c - "0") : -1;
        case (idx)
            0:       return RATE_W'(10000);
            1:       return RATE_W'(20000);
            2:       return RATE_W'(50000);
            3:       return RATE_W'(100000);
            4:       return RATE_W'(125000);
            5:       return RATE_W'(250000);
            6:       return RATE_W'(500000);
            7:       return RATE_W'(800000);
            8:       return RATE_W'(1000000);
            default: return '0;
        endcase
    endfunction

    // advances the line state by one character, reports a command when the line ends
    function automatic void parse_char(input logic [CHAR_W-1:0] c, output logic hit,
                                       output cmd_result_t r);
        logic [3:0] h;
        int         n;
        int         pairs;
        int         off;
        int         sh;
        logic       ok;
        hit = 1'b0;
        r = '0;
        if (line_pos < LINE_DEPTH)
        begin
            h = nibble_of(c);
            if (line_pos == POS_CMD)
            begin
                cmd_char = c;
                id_acc = '0;
                len_acc = '0;
                data_acc = '0;
                speed_char = '0;
            end
            else if (line_pos <= POS_ID_LAST)
            begin
                id_acc = id_acc | (ID_W'(h) << (4 * (ID_DIGITS - line_pos)));
                if (line_pos == 1)
                    speed_char = c;
            end
            else if (line_pos == POS_LEN)
            begin
                len_acc = h;
            end
            else if (line_pos <= POS_DATA_LAST)
            begin
                off = line_pos - POS_DATA_FIRST;
                sh = 8 * (off / 2) + ((off % 2 == 0) ? 4 : 0);
                data_acc = data_acc | (PAYLOAD_W'(h) << sh);
            end
            line_pos++;
        end
        if (c == CHAR_CR)
        begin
            n = (line_pos >= 2) ? line_pos - 2 : 0;
            case (cmd_char)
                CHAR_OPEN:
                begin
                    if (!bus_up)
                    begin
                        bus_up = 1'b1;
                        hit = 1'b1;
                        r.action = ACT_OPEN;
                    end
                end
                CHAR_CLOSE:
                begin
                    if (bus_up)
                    begin
                        bus_up = 1'b0;
                        hit = 1'b1;
                        r.action = ACT_CLOSE;
                    end
                end
                CHAR_SPEED:
                begin
                    if (n != 0)
                    begin
                        r.rate = speed_for(speed_char, ok);
                        hit = ok;
                        r.action = ACT_SET_RATE;
                    end
                end
                CHAR_TX:
                begin
                    if (bus_up && n >= 4 && len_acc <= MAX_BYTES)
                    begin
                        pairs = (n - 4) / 2;
                        if (pairs > len_acc)
                            pairs = len_acc;
                        r.data = (pairs >= MAX_BYTES) ? data_acc
                               : data_acc & ((PAYLOAD_W'(1) << (8 * pairs)) - 1);
                        r.id = id_acc;
                        r.len = len_acc;
                        r.action = ACT_TRANSMIT;
                        hit = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            line_pos = 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic        hit;
        cmd_result_t got;
        cmd_result_t want;
        if (!rst_n)
        begin
            line_pos = 0;
            cmd_char = '0;
            speed_char = '0;
            id_acc = '0;
            len_acc = '0;
            data_acc = '0;
            bus_up = 1'b0;
            pending_cmds.delete();
            errs = 0;
            n_checked = 0;
            fail_count <= 0;
            waiting <= 0;
            compared <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                parse_char(in_ch.rx_char, hit, got);
                if (hit)
                    pending_cmds.push_back(got);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_cmds.size() == 0)
                begin
                    errs++;
                    $display("%0t: result with none expected, got action %0d id %h len %0d",
                             $time, out_ch.action, out_ch.frame_id, out_ch.frame_length);
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    n_checked++;
                    if (out_ch.action !== want.action)
                    begin
                        errs++;
                        $display("%0t: action expected %0d got %0d",
                                 $time, want.action, out_ch.action);
                    end
                    if (out_ch.bit_rate !== want.rate)
                    begin
                        errs++;
                        $display("%0t: bit_rate expected %0d got %0d",
                                 $time, want.rate, out_ch.bit_rate);
                    end
                    if (out_ch.frame_id !== want.id)
                    begin
                        errs++;
                        $display("%0t: frame_id expected %h got %h",
                                 $time, want.id, out_ch.frame_id);
                    end
                    if (out_ch.frame_length !== want.len)
                    begin
                        errs++;
                        $display("%0t: frame_length expected %0d got %0d",
                                 $time, want.len, out_ch.frame_length);
                    end
                    if (out_ch.frame_payload !== want.data)
                    begin
                        errs++;
                        $display("%0t: frame_payload expected %h got %h",
                                 $time, want.data, out_ch.frame_payload);
                    end
                end
            end
            fail_count <= errs;
            waiting <= pending_cmds.size();
            compared <= n_checked;
        end
    end

endmodule

### tb/tb.sv
// testbench top for the ascii can command parser: character stimulus, result sink and verdict
`timescale 1ns / 1ps

module tb;
    import acp_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 100000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int waiting;
    int compared;
    int chars_sent;
    int lines_sent;
    int cycle_count;
    bit sender_calm;

    logic [CHAR_W-1:0] line_buf[$];

    acp_in_if  in_ch ();
    acp_out_if out_ch ();

    ascii_can_command_line_parser_core uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    acp_parse_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .waiting    (waiting),
        .compared   (compared)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hex digit with random case, now and then a character outside the hex ranges
    task automatic put_hex(input int v);
        int pick;
        if ($urandom_range(0, 19) == 0)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0:       line_buf.push_back(CHAR_W'(8'h3A + $urandom_range(0, 6)));
                1:       line_buf.push_back(CHAR_W'(8'h47 + $urandom_range(0, 19)));
                2:       line_buf.push_back(CHAR_W'(8'h67 + $urandom_range(0, 19)));
                default: line_buf.push_back($urandom_range(0, 1) ? 8'h2F : 8'h60);
            endcase
        end
        else if (v < 10)
            line_buf.push_back(CHAR_W'("0" + v));
        else if ($urandom_range(0, 1))
            line_buf.push_back(CHAR_W'("A" + v - 10));
        else
            line_buf.push_back(CHAR_W'("a" + v - 10));
    endtask

    task automatic play_line();
        int gap;
        foreach (line_buf[i])
        begin
            gap = sender_calm ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.rx_char <= line_buf[i];
            @(negedge clk);
            while (!in_ch.ready)
                @(negedge clk);
            @(posedge clk);
            chars_sent++;
        end
        lines_sent++;
        line_buf = {};
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL ascii_can_command_line_parser_core");
        $finish;
    end

    // result side: random stalls per item, with stretches of none
    initial
    begin
        int  stall;
        bit  steady;
        out_ch.ready = 1'b0;
        steady = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(negedge clk);
            while (!out_ch.valid)
                @(negedge clk);
            @(posedge clk);
        end
    end

    initial
    begin
        string directed_lines[];
        string s;
        int    stop_at;
        int    kind;
        int    len;
        int    nibbles;
        int    sel;
        int    first;
        in_ch.valid = 1'b0;
        in_ch.rx_char = '0;
        sender_calm = 1'b0;
        chars_sent = 0;
        lines_sent = 0;
        cycle_count = 0;
        directed_lines = '{"", "C", "O", "O", "S0", "S8", "S", "S9", "t0000", "t1239",
                           "tfff8ffffffffffffffff", "C", "t0001"};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_lines[d])
        begin
            s = directed_lines[d];
            for (int i = 0; i < s.len(); i++)
                line_buf.push_back(s[i]);
            line_buf.push_back(CHAR_CR);
            play_line();
        end

        stop_at = chars_sent + RANDOM_ITEMS;
        while (chars_sent < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
                sender_calm = !sender_calm;
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // transmit with random id, length and a data count around the length
                line_buf.push_back(CHAR_TX);
                repeat (3) put_hex($urandom_range(0, 15));
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                  : $urandom_range(0, MAX_BYTES);
                put_hex(len);
                sel = $urandom_range(0, 5);
                nibbles = (sel == 0) ? 2 * $urandom_range(0, len)
                        : (sel == 1) ? 2 * (len + $urandom_range(1, 8))
                        : 2 * len;
                if ($urandom_range(0, 7) == 0)
                    nibbles++;
                repeat (nibbles) put_hex($urandom_range(0, 15));
                line_buf.push_back(CHAR_CR);
            end
            else if (kind < 67)
            begin
                line_buf.push_back((kind < 60) ? CHAR_OPEN : CHAR_CLOSE);
                if ($urandom_range(0, 4) == 0)
                    line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
                line_buf.push_back(CHAR_CR);
            end
            else if (kind < 77)
            begin
                line_buf.push_back(CHAR_SPEED);
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    line_buf.push_back(CHAR_W'("0" + $urandom_range(0, 8)));
                else if (sel == 7)
                    line_buf.push_back("9");
                else if (sel == 9)
                    line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) == 0)
                    put_hex($urandom_range(0, 15));
                line_buf.push_back(CHAR_CR);
            end
            else if (kind < 82)
            begin
                line_buf.push_back(CHAR_TX);
                repeat ($urandom_range(0, 3)) put_hex($urandom_range(0, 15));
                line_buf.push_back(CHAR_CR);
            end
            else if (kind < 86)
            begin
                // line from one short of the buffer depth to beyond it
                sel = $urandom_range(0, 9);
                first = (sel < 6) ? CHAR_TX : (sel < 8) ? CHAR_SPEED : CHAR_OPEN;
                line_buf.push_back(CHAR_W'(first));
                repeat ($urandom_range(LINE_DEPTH - 2, LINE_DEPTH + 10))
                begin
                    if (first == CHAR_TX)
                        put_hex($urandom_range(0, 15));
                    else
                        line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
                end
                line_buf.push_back(CHAR_CR);
            end
            else if (kind < 94)
            begin
                repeat ($urandom_range(1, 12))
                    line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    line_buf.push_back(CHAR_CR);
            end
            else if (kind < 97)
            begin
                line_buf.push_back(CHAR_CR);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
                line_buf.push_back(CHAR_CR);
            end
            play_line();
        end

        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d characters in %0d lines of open, close, rate, transmit and noise",
                 chars_sent, lines_sent);
        $display("compared %0d command results, %0d failures", compared, fail_count);
        if (fail_count == 0)
            $display("PASS ascii_can_command_line_parser_core");
        else
            $display("FAIL ascii_can_command_line_parser_core");
        $finish;
    end

endmodule

### files.f
rtl/acp_pkg.sv
rtl/acp_in_if.sv
rtl/acp_out_if.sv
rtl/acp_line_decoder.sv
rtl/ascii_can_command_line_parser_core.sv
tb/acp_parse_checker.sv
tb/tb.sv
